@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the encoder modules.
// The macros expect signals named clock and reset in the calling scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, held off while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property at every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ rtl/u16u8_pkg.sv @@
// ---------------------------------------------------------------------------
// u16u8_pkg
// Types, codes and constants shared by the UTF-16 to UTF-8 encoder.
// ---------------------------------------------------------------------------
package u16u8_pkg;

   // Widths of the beats
   localparam int UNIT_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int MAX_BYTES  = 4;
   localparam int IDX_W      = 2;
   localparam int LOW_W      = 10;
   localparam int CP_W       = 21;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Range limits of the encoding
   localparam logic [UNIT_W-1:0] ASCII_MAX  = 16'h007F;
   localparam logic [UNIT_W-1:0] TWO_LIMIT  = 16'h0800;
   localparam logic [UNIT_W-1:0] SURR_FIRST = 16'hD800;
   localparam logic [UNIT_W-1:0] SURR_END   = 16'hE000;
   localparam logic [CP_W-1:0]   PLANE_BASE = 21'h10000;

   // Lead and continuation byte prefixes
   localparam logic [BYTE_W-1:0] CONT_PREFIX  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_PREFIX = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_PREFIX = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_PREFIX = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h3F;
   localparam logic [BYTE_W-1:0] END_BYTE     = 8'hFF;

   // Last byte position for each sequence length
   localparam logic [IDX_W-1:0] LAST_OF_ONE   = 2'd0;
   localparam logic [IDX_W-1:0] LAST_OF_TWO   = 2'd1;
   localparam logic [IDX_W-1:0] LAST_OF_THREE = 2'd2;
   localparam logic [IDX_W-1:0] LAST_OF_FOUR  = 2'd3;

   // Classes of an accepted input beat
   typedef enum logic [2:0] {
      KIND_END,
      KIND_PAIR,
      KIND_ONE,
      KIND_TWO,
      KIND_THREE,
      KIND_LEAD
   } kind_type;

   // One queued job: the bytes of one character or the end marker
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [IDX_W-1:0]                 last_idx;
      logic                             end_flag;
      logic                             trunc;
   } job_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

@@ rtl/utf16_to_utf8_encoder_core.sv @@
// ---------------------------------------------------------------------------
// utf16_to_utf8_encoder_core
// UTF-16 code units in, UTF-8 bytes out, one byte per result beat.
// ---------------------------------------------------------------------------
// Each request beat carries one code unit or an end-of-stream mark. The
// block answers with one to four byte beats per character (none for a
// leading surrogate, which is held and paired with the next unit) and one
// 0xFF beat with end_marker set for end of stream, truncated set when a
// leading surrogate was still held. The back end sends one byte per clock
// through its output register while rsp_stall is low. ASCII yields one
// byte, other BMP units two or three, a surrogate pair four, end of stream
// one and a held leading half none. A queue of QUEUE_DEPTH jobs sits
// between the front and the back, so new units are taken while earlier
// bytes are still leaving.
// ---------------------------------------------------------------------------
module utf16_to_utf8_encoder_core #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [u16u8_pkg::UNIT_W-1:0] req_code_unit,
   input  logic                         req_end_of_stream,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [u16u8_pkg::BYTE_W-1:0] rsp_utf8_byte,
   output logic                         rsp_last_of_char,
   output logic                         rsp_end_marker,
   output logic                         rsp_truncated
);

   u16u8_pkg::queue_status_type q_status;
   u16u8_pkg::job_type          push_job;
   u16u8_pkg::job_type          pop_job;
   logic                        push;
   logic                        pop;

   u16u8_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_unit     (req_code_unit),
      .req_end_of_stream (req_end_of_stream),
      .q_status          (q_status),
      .push              (push),
      .push_job          (push_job)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   u16u8_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .pop_job          (pop_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_utf8_byte    (rsp_utf8_byte),
      .rsp_last_of_char (rsp_last_of_char),
      .rsp_end_marker   (rsp_end_marker),
      .rsp_truncated    (rsp_truncated)
   );

endmodule

@@ rtl/u16u8_front.sv @@
// ---------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and builds one byte job per character.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [u16u8_pkg::UNIT_W-1:0]         req_code_unit,
   input  logic                                 req_end_of_stream,
   input  u16u8_pkg::queue_status_type          q_status,
   output logic                                 push,
   output u16u8_pkg::job_type                   push_job
);

   logic [u16u8_pkg::LOW_W-1:0] held_ff, held_in;
   logic                        pending_ff, pending_in;
   logic                        accept;
   u16u8_pkg::kind_type         kind;
   logic [u16u8_pkg::CP_W-1:0]  cp;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Classify the incoming beat
   always_comb begin
      if (req_end_of_stream) begin
         kind = u16u8_pkg::KIND_END;
      end else if (pending_ff) begin
         kind = u16u8_pkg::KIND_PAIR;
      end else if (req_code_unit <= u16u8_pkg::ASCII_MAX) begin
         kind = u16u8_pkg::KIND_ONE;
      end else if (req_code_unit < u16u8_pkg::TWO_LIMIT) begin
         kind = u16u8_pkg::KIND_TWO;
      end else if (req_code_unit < u16u8_pkg::SURR_FIRST ||
                   req_code_unit >= u16u8_pkg::SURR_END) begin
         kind = u16u8_pkg::KIND_THREE;
      end else begin
         kind = u16u8_pkg::KIND_LEAD;
      end
   end

   // Code point of a surrogate pair
   assign cp = u16u8_pkg::PLANE_BASE + {1'b0, held_ff, req_code_unit[u16u8_pkg::LOW_W-1:0]};

   // Build the job and the next surrogate state
   always_comb begin
      push_job   = '0;
      push       = 1'b0;
      held_in    = held_ff;
      pending_in = pending_ff;
      unique case (kind)
         u16u8_pkg::KIND_END: begin
            push_job.bytes[0] = u16u8_pkg::END_BYTE;
            push_job.last_idx = u16u8_pkg::LAST_OF_ONE;
            push_job.end_flag = 1'b1;
            push_job.trunc    = pending_ff;
            push              = accept;
            if (accept) begin
               held_in    = '0;
               pending_in = 1'b0;
            end
         end
         u16u8_pkg::KIND_PAIR: begin
            push_job.bytes[0] = u16u8_pkg::LEAD4_PREFIX | {5'd0, cp[20:18]};
            push_job.bytes[1] = u16u8_pkg::CONT_PREFIX  | {2'd0, cp[17:12]};
            push_job.bytes[2] = u16u8_pkg::CONT_PREFIX  | {2'd0, cp[11:6]};
            push_job.bytes[3] = u16u8_pkg::CONT_PREFIX  | {2'd0, cp[5:0]};
            push_job.last_idx = u16u8_pkg::LAST_OF_FOUR;
            push              = accept;
            if (accept) begin
               held_in    = '0;
               pending_in = 1'b0;
            end
         end
         u16u8_pkg::KIND_ONE: begin
            push_job.bytes[0] = req_code_unit[7:0];
            push_job.last_idx = u16u8_pkg::LAST_OF_ONE;
            push              = accept;
         end
         u16u8_pkg::KIND_TWO: begin
            push_job.bytes[0] = u16u8_pkg::LEAD2_PREFIX | {3'd0, req_code_unit[10:6]};
            push_job.bytes[1] = u16u8_pkg::CONT_PREFIX  | {2'd0, req_code_unit[5:0]};
            push_job.last_idx = u16u8_pkg::LAST_OF_TWO;
            push              = accept;
         end
         u16u8_pkg::KIND_THREE: begin
            push_job.bytes[0] = u16u8_pkg::LEAD3_PREFIX | {4'd0, req_code_unit[15:12]};
            push_job.bytes[1] = u16u8_pkg::CONT_PREFIX  | {2'd0, req_code_unit[11:6]};
            push_job.bytes[2] = u16u8_pkg::CONT_PREFIX  | {2'd0, req_code_unit[5:0]};
            push_job.last_idx = u16u8_pkg::LAST_OF_THREE;
            push              = accept;
         end
         u16u8_pkg::KIND_LEAD: begin
            // Hold the leading half, emit nothing yet
            if (accept) begin
               held_in    = req_code_unit[u16u8_pkg::LOW_W-1:0];
               pending_in = 1'b1;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // Hold the surrogate state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         pending_ff <= 1'b0;
      end else begin
         held_ff    <= held_in;
         pending_ff <= pending_in;
      end
   end

   `ASSERT_CLK(a_lead_sets_pending,
      accept && kind == u16u8_pkg::KIND_LEAD |=> pending_ff,
      "leading surrogate beat did not set the pending flag")
   `ASSERT_CLK(a_end_clears_pending,
      accept && req_end_of_stream |=> !pending_ff && held_ff == '0,
      "end of stream left surrogate state behind")

endmodule

@@ rtl/u16u8_queue.sv @@
// ---------------------------------------------------------------------------
// u16u8_queue
// Small register queue of byte jobs between the front and the back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  u16u8_pkg::job_type          push_job,
   input  logic                        pop,
   output u16u8_pkg::job_type          pop_job,
   output u16u8_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u16u8_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign status.full      = (cnt_ff == CNT_W'(DEPTH));
   assign status.not_empty = (cnt_ff != '0);
   assign pop_job          = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_CLK(a_push_pop_count,
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1,
      "queue count did not follow a lone push")

endmodule

@@ rtl/u16u8_back.sv @@
// ---------------------------------------------------------------------------
// u16u8_back
// Takes byte jobs from the queue and sends them out one byte per beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u16u8_back (
   input  logic                         clock,
   input  logic                         reset,
   input  u16u8_pkg::queue_status_type  q_status,
   input  u16u8_pkg::job_type           pop_job,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [u16u8_pkg::BYTE_W-1:0] rsp_utf8_byte,
   output logic                         rsp_last_of_char,
   output logic                         rsp_end_marker,
   output logic                         rsp_truncated
);

   u16u8_pkg::job_type              cur_ff, cur_in;
   logic                            cur_valid_ff, cur_valid_in;
   logic [u16u8_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [u16u8_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic                            last_ff, last_in;
   logic                            endm_ff, endm_in;
   logic                            trunc_ff, trunc_in;
   logic                            out_free;
   logic                            emit;
   logic                            cur_done;
   logic                            at_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;
   assign at_last  = (idx_ff == cur_ff.last_idx);
   assign cur_done = emit && at_last;
   assign pop      = q_status.not_empty && (!cur_valid_ff || cur_done);

   // Advance through the current job, load the next one as it finishes
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_in       = pop_job;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Fill the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      endm_in      = endm_ff;
      trunc_in     = trunc_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in      = cur_ff.bytes[idx_ff];
         last_in      = at_last && !cur_ff.end_flag;
         endm_in      = cur_ff.end_flag;
         trunc_in     = cur_ff.end_flag && cur_ff.trunc;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      endm_ff  <= endm_in;
      trunc_ff <= trunc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_utf8_byte    = byte_ff;
   assign rsp_last_of_char = last_ff;
   assign rsp_end_marker   = endm_ff;
   assign rsp_truncated    = trunc_ff;

   `ASSERT_CLK(a_idx_in_range,
      cur_valid_ff |-> idx_ff <= cur_ff.last_idx,
      "byte index ran past the end of the job")
   `ASSERT_CLK(a_done_releases,
      cur_done && !pop |=> !cur_valid_ff,
      "finished job stayed active")

endmodule
